// ===== src/sec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sec_pkg;

    localparam int CNT_W = 11;

    localparam logic [2:0] ACT_APPEND  = 3'd0;
    localparam logic [2:0] ACT_READ    = 3'd1;
    localparam logic [2:0] ACT_PUBLISH = 3'd2;
    localparam logic [2:0] ACT_FAIL    = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    localparam logic [1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [1:0] CFG_FLUSH     = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [15:0] FAIL_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_READ,
        OP_PUBLISH,
        OP_FAIL,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] session_tag;
        logic [31:0] epoch;
        logic [47:0] step_number;
        logic [62:0] time_ns;
        logic [31:0] force_mn;
        logic [9:0]  read_index;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic        ready_res;
        logic        loss_flag;
        logic        hazard_flag;
        logic [10:0] record_count;
        logic [31:0] chunk_number;
        logic [15:0] failure_count;
        logic [47:0] read_step;
        logic [62:0] read_time_ns;
        logic [31:0] read_force_mn;
        logic [47:0] hazard_step;
        logic [31:0] hazard_force_mn;
    } t_out_word;

    typedef struct packed {
        t_op         op;
        logic [31:0] session_tag;
        logic [31:0] epoch;
        logic [47:0] step_number;
        logic [62:0] time_ns;
        logic [31:0] force_mn;
        logic [9:0]  read_index;
    } t_cmd;

    typedef struct packed {
        logic [10:0] capacity;
        logic [10:0] flush_count;
        logic [31:0] hazard_threshold_mn;
    } t_cfg;

    typedef struct packed {
        logic [47:0] step;
        logic [62:0] time_ns;
        logic [31:0] force_mn;
    } t_entry;

endpackage
`default_nettype wire

// ===== src/step_evidence_capture_buffer_core.sv =====
// Channel   Ports                               Transfer
// command   i_start, o_busy, i_cmd              i_start high and o_busy low at a clock edge
// result    o_done, o_res                       o_done high for one cycle, always taken
// config    i_cfg_we, i_cfg_idx, i_cfg_data     i_cfg_we high at a clock edge
//
// One command per cycle sustained; a command taken passes through the front register,
// a queue slot and the back state registers before its result word goes out.
// The back end pops and finishes each command as soon as it is valid; a read registers its memory word with the state.
// The back end drains one word per cycle, so the queue never fills and o_busy stays low.
// Reset is synchronous and active low; the record memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module step_evidence_capture_buffer_core #(
    parameter int DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire sec_pkg::t_in_word i_cmd,
    output logic                   o_done,
    output sec_pkg::t_out_word     o_res,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data
);

    sec_pkg::t_cfg r_cfg;
    sec_pkg::t_cmd front_cmd;
    sec_pkg::t_cmd q_cmd;
    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity            <= 11'd1024;
            r_cfg.flush_count         <= 11'd5;
            r_cfg.hazard_threshold_mn <= 32'd11600;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sec_pkg::CFG_CAPACITY:  r_cfg.capacity            <= i_cfg_data[10:0];
                sec_pkg::CFG_FLUSH:     r_cfg.flush_count         <= i_cfg_data[10:0];
                sec_pkg::CFG_THRESHOLD: r_cfg.hazard_threshold_mn <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    sec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_word   (i_cmd),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    sec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    sec_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .i_cfg   (r_cfg),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

// ===== src/sec_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sec_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire sec_pkg::t_in_word i_word,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output sec_pkg::t_cmd          o_cmd
);

    logic          r_valid;
    logic          n_valid;
    sec_pkg::t_cmd r_cmd;
    sec_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;

    always_comb begin
        n_cmd.session_tag = i_word.session_tag;
        n_cmd.epoch       = i_word.epoch;
        n_cmd.step_number = i_word.step_number;
        n_cmd.time_ns     = i_word.time_ns;
        n_cmd.force_mn    = i_word.force_mn;
        n_cmd.read_index  = i_word.read_index;
        case (i_word.action)
            sec_pkg::ACT_APPEND:  n_cmd.op = sec_pkg::OP_APPEND;
            sec_pkg::ACT_READ:    n_cmd.op = sec_pkg::OP_READ;
            sec_pkg::ACT_PUBLISH: n_cmd.op = sec_pkg::OP_PUBLISH;
            sec_pkg::ACT_FAIL:    n_cmd.op = sec_pkg::OP_FAIL;
            sec_pkg::ACT_CLEAR:   n_cmd.op = sec_pkg::OP_CLEAR;
            default:              n_cmd.op = sec_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/sec_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sec_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sec_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output sec_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    sec_pkg::t_cmd r_slot [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_fill = r_fill + 2'd1;
            2'b01:   n_fill = r_fill - 2'd1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== src/sec_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sec_back #(
    parameter int DEPTH = 1024
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sec_pkg::t_cmd i_cmd,
    output logic               o_pop,
    input  wire sec_pkg::t_cfg i_cfg,
    output logic               o_done,
    output sec_pkg::t_out_word o_res
);

    // Count never exceeds 2047, so deeper storage would go unused.
    localparam int MEM_D = (DEPTH < 2048) ? DEPTH : 2048;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam logic [16:0] DEPTH_L = 17'(DEPTH);

    sec_pkg::t_entry r_mem [MEM_D];
    sec_pkg::t_entry r_rd_data;

    logic [10:0] r_count,   n_count;
    logic        r_have,    n_have;
    logic [31:0] r_sess,    n_sess;
    logic [31:0] r_epoch,   n_epoch;
    logic [47:0] r_next_st, n_next_st;
    logic [62:0] r_time,    n_time;
    logic        r_loss,    n_loss;
    logic        r_haz,     n_haz;
    logic [47:0] r_haz_st,  n_haz_st;
    logic [31:0] r_haz_fc,  n_haz_fc;
    logic [31:0] r_chunk,   n_chunk;
    logic [15:0] r_fail,    n_fail;

    logic        r_done;
    logic        r_acc;
    logic        r_hit;

    logic        full;
    logic        cont_ok;
    logic        app_ok;
    logic        rd_hit;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [10:0] idx_ext;

    assign o_pop   = i_valid;
    assign idx_ext = {1'b0, i_cmd.read_index};
    assign wr_addr = r_count[AW-1:0];
    assign rd_addr = idx_ext[AW-1:0];

    assign full = (r_count >= i_cfg.capacity) || ({6'd0, r_count} >= DEPTH_L);
    assign cont_ok = !r_have ||
                     (i_cmd.session_tag == r_sess && i_cmd.epoch == r_epoch &&
                      i_cmd.step_number == r_next_st && i_cmd.time_ns > r_time);
    assign app_ok = i_valid && (i_cmd.op == sec_pkg::OP_APPEND) && cont_ok && !full;
    assign rd_hit = i_valid && (i_cmd.op == sec_pkg::OP_READ) && (idx_ext < r_count);
    assign wr_en  = app_ok;

    always_comb begin
        n_count   = r_count;
        n_have    = r_have;
        n_sess    = r_sess;
        n_epoch   = r_epoch;
        n_next_st = r_next_st;
        n_time    = r_time;
        n_loss    = r_loss;
        n_haz     = r_haz;
        n_haz_st  = r_haz_st;
        n_haz_fc  = r_haz_fc;
        n_chunk   = r_chunk;
        n_fail    = r_fail;
        if (i_valid) begin
            case (i_cmd.op)
                sec_pkg::OP_APPEND: begin
                    if (app_ok) begin
                        n_count   = r_count + 11'd1;
                        n_have    = 1'b1;
                        n_sess    = i_cmd.session_tag;
                        n_epoch   = i_cmd.epoch;
                        n_next_st = i_cmd.step_number + 48'd1;
                        n_time    = i_cmd.time_ns;
                        if (!r_haz && i_cmd.force_mn >= i_cfg.hazard_threshold_mn) begin
                            n_haz    = 1'b1;
                            n_haz_st = i_cmd.step_number;
                            n_haz_fc = i_cmd.force_mn;
                        end
                    end else begin
                        n_loss = 1'b1;
                    end
                end
                sec_pkg::OP_PUBLISH: begin
                    n_count = 11'd0;
                    n_chunk = r_chunk + 32'd1;
                    n_fail  = 16'd0;
                end
                sec_pkg::OP_FAIL: begin
                    if (r_fail != sec_pkg::FAIL_MAX) begin
                        n_fail = r_fail + 16'd1;
                    end
                end
                sec_pkg::OP_CLEAR: begin
                    n_count = 11'd0;
                    n_have  = 1'b0;
                    n_loss  = 1'b0;
                    n_haz   = 1'b0;
                    n_chunk = 32'd0;
                    n_fail  = 16'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 11'd0;
            r_have  <= 1'b0;
            r_loss  <= 1'b0;
            r_haz   <= 1'b0;
            r_chunk <= 32'd0;
            r_fail  <= 16'd0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_have  <= n_have;
            r_loss  <= n_loss;
            r_haz   <= n_haz;
            r_chunk <= n_chunk;
            r_fail  <= n_fail;
            r_done  <= i_valid;
        end
        r_sess    <= n_sess;
        r_epoch   <= n_epoch;
        r_next_st <= n_next_st;
        r_time    <= n_time;
        r_haz_st  <= n_haz_st;
        r_haz_fc  <= n_haz_fc;
        r_acc     <= app_ok;
        r_hit     <= rd_hit;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{step: i_cmd.step_number, time_ns: i_cmd.time_ns,
                                force_mn: i_cmd.force_mn};
        end
        if (rd_hit) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // State registers already hold the post-action values when the word goes out.
    assign o_done = r_done;
    always_comb begin
        o_res.accepted        = r_acc;
        o_res.ready_res       = (r_count >= i_cfg.flush_count) || r_loss || r_haz;
        o_res.loss_flag       = r_loss;
        o_res.hazard_flag     = r_haz;
        o_res.record_count    = r_count;
        o_res.chunk_number    = r_chunk;
        o_res.failure_count   = r_fail;
        o_res.read_step       = r_hit ? r_rd_data.step : 48'd0;
        o_res.read_time_ns    = r_hit ? r_rd_data.time_ns : 63'd0;
        o_res.read_force_mn   = r_hit ? r_rd_data.force_mn : 32'd0;
        o_res.hazard_step     = r_haz ? r_haz_st : 48'd0;
        o_res.hazard_force_mn = r_haz ? r_haz_fc : 32'd0;
    end

endmodule
`default_nettype wire
